// ----- hw/rtl/mma_pkg.sv -----
// Shared types, constants and helpers for the multichannel moving average unit.
`default_nettype none

package mma_pkg;

   localparam int CHANNELS   = 64;
   localparam int WINDOW_MAX = 256;

   localparam int CH_W    = 6;
   localparam int SMP_W   = 32;
   localparam int SUM_W   = 40;
   localparam int WIN_W   = 9;
   localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
   localparam int POS_W   = $clog2(WINDOW_MAX);
   localparam int CH_AW   = $clog2(CHANNELS);
   localparam int RING_AW = CH_AW + POS_W;

   localparam int QDEPTH = 2;
   localparam int QP_W   = $clog2(QDEPTH);
   localparam int QC_W   = $clog2(QDEPTH + 1);

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   // register index (byte address / 4)
   localparam logic REG_WINDOW_LENGTH = 1'b0;
   localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(1);

   typedef struct packed {
      logic [CH_W-1:0]  channel;
      logic [SMP_W-1:0] sample;
      logic             series_start;
      logic             in_range;
   } item_type;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [CNT_W-1:0] cnt;
      logic [POS_W-1:0] pos;
   } chan_state_type;

   typedef struct packed {
      logic [CH_W-1:0]  channel;
      logic [SMP_W-1:0] average;
      logic             valid_res;
   } result_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_RING,
      ST_UPDATE,
      ST_DIVIDE,
      ST_EMIT
   } back_state_type;

   // zero acts as one, anything past the ring depth as the ring depth
   function automatic logic [WIN_W-1:0] effective_window(input logic [WIN_W-1:0] w);
      logic [WIN_W-1:0] r;
      r = w;
      if (w == '0) begin
         r = WIN_W'(1);
      end else if (w > WIN_W'(WINDOW_MAX)) begin
         r = WIN_W'(WINDOW_MAX);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mma_front.sv -----
// Input side: takes items, flags the channel range and queues them for the back end.
`default_nettype none

module mma_front
   import mma_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [SMP_W-1:0] req_tdata,   // sample
   input  wire logic [CH_W:0]    req_tuser,   // channel, series_start
   output item_type              item,
   output logic                  item_valid,
   input  wire logic             item_pop
);

   item_type         queue_ff [QDEPTH];
   logic [QP_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QP_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QC_W-1:0]  count_ff, count_in;
   item_type         incoming;
   logic             push;
   logic             pop;

   always_comb begin
      incoming.channel      = req_tuser[CH_W-1:0];
      incoming.sample       = req_tdata;
      incoming.series_start = req_tuser[CH_W];
      incoming.in_range     = {1'b0, req_tuser[CH_W-1:0]} < (CH_W + 1)'(CHANNELS);
   end

   assign req_tready = count_ff < QC_W'(QDEPTH);
   assign item_valid = count_ff != '0;
   assign item       = queue_ff[rd_ptr_ff];
   assign push       = req_tvalid & req_tready;
   assign pop        = item_pop & item_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QP_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QP_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= incoming;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/mma_div.sv -----
// Radix-2 restoring divider: signed running sum over window length, saturated to 32 bits.
`default_nettype none

module mma_div
   import mma_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [SUM_W-1:0] dividend,
   input  wire logic [WIN_W-1:0] divisor,
   output logic                  done,
   output logic [SMP_W-1:0]      quotient
);

   localparam int STEP_W = $clog2(SUM_W);
   localparam logic [SUM_W-1:0] POS_LIMIT = SUM_W'({1'b0, {(SMP_W - 1){1'b1}}});
   localparam logic [SUM_W-1:0] NEG_LIMIT = SUM_W'({1'b1, {(SMP_W - 1){1'b0}}});

   logic              busy_ff;
   logic              done_ff;
   logic              neg_ff;
   logic [WIN_W-1:0]  rem_ff;
   logic [WIN_W-1:0]  div_ff;
   logic [SUM_W-1:0]  quo_ff;
   logic [STEP_W-1:0] step_ff;
   logic [WIN_W:0]    rem_sh;
   logic [WIN_W:0]    rem_sub;
   logic              fits;
   logic [SUM_W-1:0]  neg_mag;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[SUM_W-1]};
      fits    = rem_sh >= {1'b0, div_ff};
      rem_sub = rem_sh - {1'b0, div_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && step_ff == STEP_W'(SUM_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff  <= dividend[SUM_W-1];
         quo_ff  <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
         div_ff  <= divisor;
         rem_ff  <= '0;
         step_ff <= '0;
      end else if (busy_ff) begin
         quo_ff  <= {quo_ff[SUM_W-2:0], fits};
         rem_ff  <= fits ? rem_sub[WIN_W-1:0] : rem_sh[WIN_W-1:0];
         step_ff <= step_ff + 1'b1;
      end
   end

   // quo_ff holds the magnitude once the last step is in
   assign neg_mag = ~quo_ff + 1'b1;
   assign done    = done_ff;

   always_comb begin
      if (neg_ff) begin
         quotient = (quo_ff > NEG_LIMIT) ? NEG_LIMIT[SMP_W-1:0] : neg_mag[SMP_W-1:0];
      end else begin
         quotient = (quo_ff > POS_LIMIT) ? POS_LIMIT[SMP_W-1:0] : quo_ff[SMP_W-1:0];
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/mma_back.sv -----
// Back end: per-channel state and sample ring, running-sum update, division and result register.
`default_nettype none

module mma_back
   import mma_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire item_type         item,
   input  wire logic             item_valid,
   output logic                  item_pop,
   input  wire logic [WIN_W-1:0] window_length,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [SMP_W-1:0]      rsp_tdata,   // average
   output logic [CH_W:0]         rsp_tuser    // out_channel, valid_res
);

   back_state_type   state_ff, state_in;
   item_type         item_ff;
   logic [WIN_W-1:0] w_ff;
   chan_state_type   cur_ff;
   result_type       res_ff;
   result_type       rsp_ff;
   logic             rsp_valid_ff;

   chan_state_type   st_mem [CHANNELS];
   chan_state_type   st_rdata_ff;
   logic [CHANNELS-1:0] st_valid_ff;
   logic [SMP_W-1:0] ring_mem [CHANNELS * WINDOW_MAX];
   logic [SMP_W-1:0] ring_rdata_ff;

   logic [CH_AW-1:0]   ch_idx;
   chan_state_type     raw;
   logic [RING_AW-1:0] ring_raddr;
   logic               drop;
   logic [SUM_W-1:0]   old_ext;
   logic [SUM_W-1:0]   smp_ext;
   chan_state_type     new_st;
   logic               out_free;
   logic               st_we;
   logic               ring_we;
   logic               div_start;
   logic               div_done;
   logic [SMP_W-1:0]   div_q;
   logic               rsp_load;

   assign ch_idx = item_ff.channel[CH_AW-1:0];

   // an unseen channel, or one being restarted, begins from all-zero state
   always_comb begin
      raw        = (st_valid_ff[ch_idx] && !item_ff.series_start) ? st_rdata_ff : '0;
      ring_raddr = {ch_idx, raw.pos - w_ff[POS_W-1:0]};
   end

   always_comb begin
      drop    = cur_ff.cnt >= w_ff;
      old_ext = drop ? {{(SUM_W - SMP_W){ring_rdata_ff[SMP_W-1]}}, ring_rdata_ff} : '0;
      smp_ext = {{(SUM_W - SMP_W){item_ff.sample[SMP_W-1]}}, item_ff.sample};
      new_st.sum = cur_ff.sum - old_ext + smp_ext;
      new_st.cnt = (cur_ff.cnt == CNT_W'(WINDOW_MAX)) ? cur_ff.cnt : cur_ff.cnt + 1'b1;
      new_st.pos = cur_ff.pos + 1'b1;
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in  = state_ff;
      item_pop  = 1'b0;
      st_we     = 1'b0;
      ring_we   = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               state_in = item.in_range ? ST_FETCH : ST_EMIT;
            end
         end
         ST_FETCH: begin
            state_in = ST_RING;
         end
         ST_RING: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            st_we   = 1'b1;
            ring_we = 1'b1;
            if (new_st.cnt >= w_ff) begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         st_valid_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (st_we) begin
            st_valid_ff[ch_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         item_ff <= item;
         w_ff    <= effective_window(window_length);
         res_ff  <= '{channel: item.channel, average: '0, valid_res: 1'b0};
      end
      if (state_ff == ST_RING) begin
         cur_ff <= raw;
      end else if (state_ff == ST_UPDATE) begin
         cur_ff <= new_st;
      end
      if (state_ff == ST_DIVIDE && div_done) begin
         res_ff.average   <= div_q;
         res_ff.valid_res <= 1'b1;
      end
      if (rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         st_mem[ch_idx] <= new_st;
      end
      st_rdata_ff <= st_mem[ch_idx];
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[{ch_idx, cur_ff.pos}] <= item_ff.sample;
      end
      ring_rdata_ff <= ring_mem[ring_raddr];
   end

   mma_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (new_st.sum),
      .divisor  (w_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.average;
   assign rsp_tuser  = {rsp_ff.valid_res, rsp_ff.channel};

`ifndef SYNTHESIS
   a_div_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIVIDE)
      else $error("divider finished outside the divide state");

   a_valid_needs_full_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && res_ff.valid_res) |-> cur_ff.cnt >= w_ff)
      else $error("valid average before the window filled");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      st_we |-> new_st.cnt <= CNT_W'(WINDOW_MAX))
      else $error("fill count beyond ring depth");

   a_one_result_per_item: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> state_ff == ST_IDLE && rsp_valid_ff)
      else $error("result load did not return to idle");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/multichannel_moving_average_unit.sv -----
// Top level: configuration registers, input queue and moving-average back end.
//
//   channel   direction  handshake             payload
//   req_*     in         req_tvalid/tready     tdata: sample; tuser: channel, series_start
//   rsp_*     out        rsp_tvalid/tready     tdata: average; tuser: out_channel, valid_res
//   csr_*     in         APB write/read        window_length at byte address 0
//
// An item with a filled window waits on the bit-serial divider
// (one quotient bit per cycle over the 40-bit running sum); warm-up items skip it.
// The two-entry input queue takes items while the back end works; req_tready drops
// once both entries are waiting.
// Reset is synchronous; per-channel state is cleared at once through valid bits.
// A held result on rsp_* stalls the back end, and the input too once the queue is full.
`default_nettype none

module multichannel_moving_average_unit
   import mma_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [SMP_W-1:0]  req_tdata,   // sample
   input  wire logic [CH_W:0]     req_tuser,   // [5:0] channel, [6] series_start
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [SMP_W-1:0]       rsp_tdata,   // average
   output logic [CH_W:0]          rsp_tuser,   // [5:0] out_channel, [6] valid_res
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0]      csr_prdata,
   output logic                   csr_pready
);

   logic [WIN_W-1:0] window_length_ff;
   logic             hit;
   item_type         item;
   logic             item_valid;
   logic             item_pop;

   assign csr_pready = 1'b1;
   assign hit        = csr_paddr[CSR_AW-1:2] == REG_WINDOW_LENGTH;
   assign csr_prdata = hit ? CSR_DW'(window_length_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= WINDOW_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && hit) begin
         window_length_ff <= csr_pwdata[WIN_W-1:0];
      end
   end

   mma_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item       (item),
      .item_valid (item_valid),
      .item_pop   (item_pop)
   );

   mma_back u_back (
      .clock         (clock),
      .reset         (reset),
      .item          (item),
      .item_valid    (item_valid),
      .item_pop      (item_pop),
      .window_length (window_length_ff),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser)
   );

endmodule

`default_nettype wire

// ----- bench/tb_multichannel_moving_average_unit.sv -----
// Self-checking testbench for the multichannel moving average unit.
`default_nettype none

module tb_multichannel_moving_average_unit;
   import mma_pkg::*;

   localparam int                HALF_PERIOD  = 5;
   localparam int                LONG_HOLD    = 300;
   localparam int                DRAIN_CYCLES = 100;
   localparam logic [CSR_AW-1:0] WINDOW_ADDR  = CSR_AW'(4 * REG_WINDOW_LENGTH);
   localparam logic [SMP_W-1:0]  SAMPLE_MAX   = 32'h7FFF_FFFF;
   localparam logic [SMP_W-1:0]  SAMPLE_MIN   = 32'h8000_0000;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_tvalid  = 1'b0;
   wire               req_tready;
   logic [SMP_W-1:0]  req_tdata   = '0;   // sample
   logic [CH_W:0]     req_tuser   = '0;   // [5:0] channel, [6] series_start
   wire               rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   wire  [SMP_W-1:0]  rsp_tdata;          // average
   wire  [CH_W:0]     rsp_tuser;          // [5:0] out_channel, [6] valid_res
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0] csr_paddr   = '0;
   logic [CSR_DW-1:0] csr_pwdata  = '0;
   wire  [CSR_DW-1:0] csr_prdata;
   wire               csr_pready;

   multichannel_moving_average_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #HALF_PERIOD clock = ~clock;

   // predictor state, one set per channel
   logic [SMP_W-1:0] sample_hist [CHANNELS][WINDOW_MAX];
   logic [SUM_W-1:0] chan_sum    [CHANNELS];
   int unsigned      chan_fill   [CHANNELS];
   int unsigned      chan_pos    [CHANNELS];
   logic [WIN_W-1:0] window_cfg;

   result_type pending_averages [$];
   int         mismatch_count = 0;
   bit         quiet_tail     = 1'b0;
   int         send_gap_pct   = 0;
   int         rsp_stall_pct  = 0;
   bit         hold_request   = 1'b0;
   int         hold_left      = 0;
   int         stall_left     = 0;

   function automatic int unsigned active_window();
      int unsigned w;
      w = window_cfg;
      if (w == 0) begin
         w = 1;
      end else if (w > WINDOW_MAX) begin
         w = WINDOW_MAX;
      end
      return w;
   endfunction

   task automatic predict_average(input logic [CH_W-1:0] ch, input logic [SMP_W-1:0] smp,
                                  input logic start);
      int unsigned      w;
      int unsigned      p;
      int unsigned      oldest;
      logic [SUM_W-1:0] acc;
      longint           q;
      result_type       r;
      w = active_window();
      r.channel   = ch;
      r.average   = '0;
      r.valid_res = 1'b0;
      if (start) begin
         chan_sum[ch]  = '0;
         chan_fill[ch] = 0;
         chan_pos[ch]  = 0;
      end
      p   = chan_pos[ch];
      acc = chan_sum[ch];
      if (chan_fill[ch] >= w) begin
         oldest = (p + WINDOW_MAX - w) % WINDOW_MAX;
         acc = acc - {{(SUM_W-SMP_W){sample_hist[ch][oldest][SMP_W-1]}}, sample_hist[ch][oldest]};
      end
      acc = acc + {{(SUM_W-SMP_W){smp[SMP_W-1]}}, smp};
      sample_hist[ch][p] = smp;
      chan_pos[ch] = (p + 1) % WINDOW_MAX;
      if (chan_fill[ch] < WINDOW_MAX) begin
         chan_fill[ch]++;
      end
      chan_sum[ch] = acc;
      if (chan_fill[ch] >= w) begin
         // signed division truncates toward zero; an inconsistent sum may overflow 32 bits
         q = longint'($signed(acc)) / longint'(w);
         if (q > longint'(32'sh7FFF_FFFF)) begin
            q = longint'(32'sh7FFF_FFFF);
         end else if (q < -longint'(64'sh8000_0000)) begin
            q = -longint'(64'sh8000_0000);
         end
         r.average   = q[SMP_W-1:0];
         r.valid_res = 1'b1;
      end
      pending_averages = {pending_averages, r};
   endtask

   // result side: check every accepted item, then decide the next tready
   always @(posedge clock) begin : rsp_side
      result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_averages.size() == 0) begin
               $display("%0t: unexpected result, got channel %0d average %h valid %b",
                        $time, rsp_tuser[CH_W-1:0], rsp_tdata, rsp_tuser[CH_W]);
               mismatch_count++;
            end else begin
               want = pending_averages.pop_front();
               if (rsp_tuser[CH_W-1:0] !== want.channel) begin
                  $display("%0t: out_channel mismatch, expected %0d got %0d",
                           $time, want.channel, rsp_tuser[CH_W-1:0]);
                  mismatch_count++;
               end
               if (rsp_tdata !== want.average) begin
                  $display("%0t: average mismatch on channel %0d, expected %h got %h",
                           $time, want.channel, want.average, rsp_tdata);
                  mismatch_count++;
               end
               if (rsp_tuser[CH_W] !== want.valid_res) begin
                  $display("%0t: valid_res mismatch on channel %0d, expected %b got %b",
                           $time, want.channel, want.valid_res, rsp_tuser[CH_W]);
                  mismatch_count++;
               end
            end
         end
         if (hold_request) begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 99) < rsp_stall_pct) begin
            stall_left = $urandom_range(0, 13);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // valid stays up between back-to-back items; only a gap or a drain lowers it
   task automatic send_sample(input logic [CH_W-1:0] ch, input logic [SMP_W-1:0] smp,
                              input logic start);
      req_tvalid <= 1'b1;
      req_tdata  <= smp;
      req_tuser  <= {start, ch};
      do @(posedge clock); while (!req_tready);
      predict_average(ch, smp, start);
   endtask

   task automatic sender_gap();
      if (!quiet_tail && $urandom_range(0, 99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   task automatic wait_all_results();
      req_tvalid <= 1'b0;
      while (pending_averages.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write then read back; only called with nothing in flight
   task automatic write_window(input logic [WIN_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= WINDOW_ADDR;
      csr_pwdata  <= CSR_DW'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      window_cfg = value;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[WIN_W-1:0] !== window_cfg) begin
         $display("%0t: window_length readback mismatch, expected %0d got %0d",
                  $time, window_cfg, csr_prdata[WIN_W-1:0]);
         mismatch_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic logic [SMP_W-1:0] pick_sample();
      logic [SMP_W-1:0] s;
      case ($urandom_range(0, 9))
         0: s = SAMPLE_MAX;
         1: s = SAMPLE_MIN;
         2: s = SMP_W'(int'($urandom_range(0, 2000)) - 1000);
         3: s = '1;
         4: s = {16'($urandom), 16'h0000};
         default: s = $urandom;
      endcase
      return s;
   endfunction

   // default window of one: average equals the sample, extremes of both fields
   task automatic test_reset_window();
      send_sample(6'd0,  SAMPLE_MAX,   1'b1);
      send_sample(6'd63, SAMPLE_MIN,   1'b1);
      send_sample(6'd0,  '0,           1'b0);
      send_sample(6'd63, '1,           1'b0);
      send_sample(6'd21, 32'h0001_8000, 1'b0);
      wait_all_results();
   endtask

   // warm-up results, then negative means that truncate toward zero
   task automatic test_warmup_truncation();
      write_window(9'd4);
      send_sample(6'd10, -32'sd1, 1'b1);
      send_sample(6'd63, 32'd5,   1'b1);
      send_sample(6'd10, -32'sd2, 1'b0);
      send_sample(6'd10, -32'sd3, 1'b0);
      send_sample(6'd63, 32'd6,   1'b0);
      send_sample(6'd10, -32'sd4, 1'b0);
      send_sample(6'd10, -32'sd5, 1'b0);
      wait_all_results();
   endtask

   // zero acts as one, a length past the ring depth is clamped
   task automatic test_window_extremes();
      write_window(9'd0);
      send_sample(6'd33, 32'h1234_5678, 1'b1);
      wait_all_results();
      write_window(9'h1FF);
      send_sample(6'd33, 32'hDEAD_BEEF, 1'b1);
      send_sample(6'd33, 32'h0000_0001, 1'b0);
      wait_all_results();
   endtask

   // shrinking the window mid-series leaves a stale sum that saturates the mean
   task automatic test_window_change_mid_series();
      write_window(9'd16);
      send_sample(6'd5, SAMPLE_MAX, 1'b1);
      send_sample(6'd5, SAMPLE_MAX, 1'b0);
      send_sample(6'd6, SAMPLE_MIN, 1'b1);
      send_sample(6'd6, SAMPLE_MIN, 1'b0);
      send_sample(6'd5, SAMPLE_MAX, 1'b0);
      send_sample(6'd6, SAMPLE_MIN, 1'b0);
      wait_all_results();
      write_window(9'd2);
      send_sample(6'd5, SAMPLE_MAX, 1'b0);
      send_sample(6'd6, SAMPLE_MIN, 1'b0);
      send_sample(6'd5, 32'd100,    1'b1);
      send_sample(6'd5, 32'd300,    1'b0);
      wait_all_results();
   endtask

   // receiver holds off for a long stretch while items keep coming
   task automatic test_backpressure();
      int k;
      write_window(9'd1);
      send_gap_pct = 0;
      hold_request = 1'b1;
      for (k = 0; k < 24; k++) begin
         send_sample(6'($urandom), pick_sample(), 1'($urandom_range(0, 1)));
      end
      wait_all_results();
   endtask

   // phases of well-formed series per window setting; each phase starts from a full drain
   task automatic test_random_phases();
      int unsigned      phase_windows [8];
      logic [CH_W-1:0]  active [6];
      int               i;
      int               k;
      int               n_chan;
      int               n_items;
      logic [CH_W-1:0]  ch;
      phase_windows = '{3, 8, 1, 256, 2, 33, 0, 5};
      for (i = 0; i < 8; i++) begin
         wait_all_results();
         write_window(WIN_W'(phase_windows[i]));
         if (i == 7) begin
            quiet_tail = 1'b1;
         end else begin
            send_gap_pct  = $urandom_range(0, 2) * 17;
            rsp_stall_pct = $urandom_range(0, 2) * 17;
         end
         if (active_window() >= 64) begin
            n_chan  = 1;
            n_items = active_window() + 24;
         end else begin
            n_chan  = $urandom_range(1, 6);
            n_items = 48;
         end
         for (k = 0; k < 6; k++) begin
            active[k] = 6'($urandom);
         end
         for (k = 0; k < n_items; k++) begin
            ch = active[$urandom_range(0, n_chan - 1)];
            // occasional stray channel
            if ($urandom_range(0, 99) < 5) begin
               ch = 6'($urandom);
            end
            sender_gap();
            send_sample(ch, pick_sample(), $urandom_range(0, 99) < 3);
         end
      end
      wait_all_results();
   endtask

   initial begin
      int c;
      window_cfg = WINDOW_RESET;
      for (c = 0; c < CHANNELS; c++) begin
         chan_sum[c]  = '0;
         chan_fill[c] = 0;
         chan_pos[c]  = 0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_window();
      test_warmup_truncation();
      test_window_extremes();
      test_window_change_mid_series();
      test_backpressure();
      test_random_phases();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_averages.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

`default_nettype wire
